FILE: rtl/indexed_list_engine_macros.svh
// Assertion helpers for the indexed list engine.
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

// Checked on every rising edge of clk, suspended while reset is asserted.
`define ILE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ILE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ile_pkg.sv
`timescale 1ns / 1ps

package ile_pkg;

  localparam int CAPACITY   = 16;
  localparam int ELEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Command codes; code 7 is unused and completes with no effect.
  typedef enum logic [2:0] {
    CMD_APPEND     = 3'd0,
    CMD_INSERT     = 3'd1,
    CMD_DELETE     = 3'd2,
    CMD_READ       = 3'd3,
    CMD_OVERWRITE  = 3'd4,
    CMD_FIND_FIRST = 3'd5,
    CMD_FIND_LAST  = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_SCAN
  } state_t;

endpackage

FILE: rtl/indexed_list_engine.sv
`timescale 1ns / 1ps

// Indexed list engine: an ordered list of up to CAPACITY signed elements held
// in one synchronous RAM. A request is taken on a rising edge where start is
// high and busy is low; busy stays high until its result has been issued. The
// result appears on the out_ ports for exactly one cycle, flagged by
// out_valid, and cannot be stalled, so the receiver must take it in that
// cycle. A new request may be issued in the same cycle that a result is shown.
// Append, read, overwrite, the unused command code and every rejected request
// go from acceptance to result by reading the addressed entry, then deciding
// and writing back. Insert and delete at position p also move entries: the
// entries at and above p (for insert) or above p (for delete) are moved one
// per cycle through the single RAM write port, before the result is issued.
// Find first reads the entries in order and stops at the first match; find
// last always reads every entry, one RAM read per entry. No clearing pass
// is needed after reset: RAM contents are only used below the element count.
module indexed_list_engine
  import ile_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   in_command,
  input  logic [IDX_W-1:0]             in_position,
  input  logic signed [ELEM_WIDTH-1:0] in_value,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic signed [ELEM_WIDTH-1:0] out_data,
  output logic [IDX_W-1:0]             out_found_position,
  output logic [CNT_W-1:0]             out_count,
  output logic                         out_empty_res
);

  `include "indexed_list_engine_macros.svh"

  state_t                state_r, state_nxt;
  logic [2:0]            cmd_r, cmd_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic [ELEM_WIDTH-1:0] val_r, val_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  hit_r, hit_nxt;
  logic [IDX_W-1:0]      fpos_r, fpos_nxt;
  logic [ELEM_WIDTH-1:0] data_r, data_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [ELEM_WIDTH-1:0] out_data_r;
  logic [IDX_W-1:0]      out_fpos_r;
  logic [CNT_W-1:0]      out_count_r;
  logic                  out_empty_r;

  logic                  accept;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [ELEM_WIDTH-1:0] mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;
  logic [ELEM_WIDTH-1:0] mem_rdata;

  logic                  fin;
  status_t               fin_status;
  logic [ELEM_WIDTH-1:0] fin_data;
  logic [IDX_W-1:0]      fin_fpos;

  logic [CNT_W-1:0]      pos_ext;
  logic                  out_of_range;
  logic                  is_full;
  logic                  match;
  logic                  last_entry;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // The element store. Every entry below count_r has been written.
  ile_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign pos_ext      = CNT_W'(pos_r);
  assign out_of_range = (pos_ext >= count_r);
  assign is_full      = (count_r >= CNT_W'(CAPACITY));
  assign match        = (mem_rdata == val_r);
  assign last_entry   = (CNT_W'(idx_r) == count_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    pos_r  <= pos_nxt;
    val_r  <= val_nxt;
    idx_r  <= idx_nxt;
    hit_r  <= hit_nxt;
    fpos_r <= fpos_nxt;
    data_r <= data_nxt;
  end

  // Sequencer. The read issued in one cycle returns its data in the next, so
  // each state consumes the entry requested by the state before it. Shifts
  // always read on the far side of the entry being written, so a read never
  // targets the entry written in the same cycle.
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    hit_nxt    = hit_r;
    fpos_nxt   = fpos_r;
    data_nxt   = data_r;
    count_nxt  = count_r;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = mem_rdata;
    mem_raddr  = in_position;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_data   = '0;
    fin_fpos   = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt   = in_command;
          pos_nxt   = in_position;
          val_nxt   = in_value;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        // mem_rdata holds the entry at the requested position here.
        case (cmd_r)
          CMD_APPEND: begin
            fin = 1'b1;
            if (is_full) begin
              fin_status = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = count_r[IDX_W-1:0];
              mem_wdata = val_r;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          CMD_INSERT: begin
            if (out_of_range) begin
              fin        = 1'b1;
              fin_status = ST_RANGE;
            end else if (is_full) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end else begin
              // Move entries up, starting from the top one.
              mem_raddr = IDX_W'(count_r - CNT_W'(1));
              idx_nxt   = count_r[IDX_W-1:0];
              state_nxt = S_SHIFT_UP;
            end
          end
          CMD_DELETE: begin
            if (out_of_range) begin
              fin        = 1'b1;
              fin_status = ST_RANGE;
            end else if (pos_ext + CNT_W'(1) >= count_r) begin
              // Removing the last entry needs no shift.
              fin       = 1'b1;
              fin_data  = mem_rdata;
              count_nxt = count_r - CNT_W'(1);
            end else begin
              data_nxt  = mem_rdata;
              mem_raddr = pos_r + IDX_W'(1);
              idx_nxt   = pos_r;
              state_nxt = S_SHIFT_DN;
            end
          end
          CMD_READ: begin
            fin = 1'b1;
            if (out_of_range) begin
              fin_status = ST_RANGE;
            end else begin
              fin_data = mem_rdata;
            end
          end
          CMD_OVERWRITE: begin
            fin = 1'b1;
            if (out_of_range) begin
              fin_status = ST_RANGE;
            end else begin
              fin_data  = mem_rdata;
              mem_we    = 1'b1;
              mem_waddr = pos_r;
              mem_wdata = val_r;
            end
          end
          CMD_FIND_FIRST, CMD_FIND_LAST: begin
            if (count_r == '0) begin
              fin        = 1'b1;
              fin_status = ST_NOTFOUND;
            end else begin
              mem_raddr = '0;
              idx_nxt   = '0;
              hit_nxt   = 1'b0;
              state_nxt = S_SCAN;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      S_SHIFT_UP: begin
        // mem_rdata holds entry idx_r - 1 unless the insert slot is reached.
        mem_we = 1'b1;
        if (idx_r == pos_r) begin
          mem_waddr = pos_r;
          mem_wdata = val_r;
          count_nxt = count_r + CNT_W'(1);
          fin       = 1'b1;
        end else begin
          mem_waddr = idx_r;
          mem_wdata = mem_rdata;
          mem_raddr = idx_r - IDX_W'(2);
          idx_nxt   = idx_r - IDX_W'(1);
        end
      end

      S_SHIFT_DN: begin
        // mem_rdata holds entry idx_r + 1.
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = mem_rdata;
        mem_raddr = idx_r + IDX_W'(2);
        idx_nxt   = idx_r + IDX_W'(1);
        if (CNT_W'(idx_r) + CNT_W'(2) >= count_r) begin
          fin       = 1'b1;
          fin_data  = data_r;
          count_nxt = count_r - CNT_W'(1);
        end
      end

      S_SCAN: begin
        // mem_rdata holds entry idx_r.
        if (match) begin
          hit_nxt  = 1'b1;
          fpos_nxt = idx_r;
        end
        if (match && (cmd_r == CMD_FIND_FIRST)) begin
          fin      = 1'b1;
          fin_fpos = idx_r;
        end else if (last_entry) begin
          fin = 1'b1;
          if (match) begin
            fin_fpos = idx_r;
          end else if (hit_r) begin
            fin_fpos = fpos_r;
          end else begin
            fin_status = ST_NOTFOUND;
          end
        end else begin
          mem_raddr = idx_r + IDX_W'(1);
          idx_nxt   = idx_r + IDX_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = S_IDLE;
    end
  end

  // Result register: loaded on the edge that ends the final cycle of a request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_status_r <= fin_status;
      out_data_r   <= fin_data;
      out_fpos_r   <= fin_fpos;
      out_count_r  <= count_nxt;
      out_empty_r  <= (count_nxt == '0);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_data           = out_data_r;
  assign out_found_position = out_fpos_r;
  assign out_count          = out_count_r;
  assign out_empty_res      = out_empty_r;

  // A request is taken while idle and finishes in a later state, so results never come back to back.
  `ILE_ASSERT(a_result_single, out_valid_r |=> !out_valid_r, "result strobe held two cycles")
  // The element count only moves together with a result.
  `ILE_ASSERT(a_count_with_result, (count_r != $past(count_r)) |-> out_valid_r,
              "count changed without a result")
  // The reported count is the live count at the moment the result is shown.
  `ILE_ASSERT(a_result_count, out_valid_r |-> (out_count_r == count_r),
              "reported count differs from stored count")
  // The store is never written while the engine is idle.
  `ILE_ASSERT_ALWAYS(a_no_idle_write, (state_r == S_IDLE) |-> !mem_we,
                     "store written while idle")
  // The count never exceeds the capacity.
  `ILE_ASSERT(a_count_bound, count_r <= CNT_W'(CAPACITY), "count above capacity")

endmodule

FILE: rtl/ile_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data.
module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
